// ===== src/ppa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppa_pkg - shared constants for the per-CPU page allocator
// Field widths, operation and status codes, register indexes, reset values.
// ----------------------------------------------------------------------------
package ppa_pkg;

	localparam int ADDR_W     = 34;
	localparam int LINK_W     = 16;
	localparam int TDATA_W    = 40;
	localparam int S_TUSER_W  = 5;
	localparam int M_TUSER_W  = 2;
	localparam int CFG_IDX_W  = 1;

	localparam logic [LINK_W-1:0] EMPTY_LINK = 16'hFFFF;

	// operation codes
	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OOM = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

	localparam logic [ADDR_W-1:0] HEAP_BASE_RST  = 34'd2149580800;
	localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 34'd2281701376;

endpackage
`default_nettype wire

// ===== src/ppa_link_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppa_link_ram - next-page link store
// Single write port, one registered read port, no reset.
// ----------------------------------------------------------------------------
module ppa_link_ram #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [ppa_pkg::LINK_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [ppa_pkg::LINK_W-1:0] rdata
);
	import ppa_pkg::*;

	logic [LINK_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/percpu_page_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// percpu_page_allocator - per-CPU LIFO free-list page allocator
// Init / alloc / free over one link RAM and a small set of list heads.
// ----------------------------------------------------------------------------
// One word is processed at a time; s_tready is high only while the block is
// idle. Pages live as indices in a next-link RAM with a registered read port;
// list heads are flops. A free checks the address, then pushes the page. An
// alloc pops from the requesting CPU's list when it has a page, else steals
// from the next non-empty list, wrapping; the scan checks one head per cycle.
// An init checks the bounds and splits the heap into spans (a three-step
// reciprocal multiply), then for each CPU sets up its span and pushes its
// pages (one link RAM write per cycle); with the limit not above the base it
// ends after the bounds check. A result that cannot be handed over because
// the output register is still full waits one register deep.
// ----------------------------------------------------------------------------
module percpu_page_allocator #(
	parameter int NUM_CPUS   = 8,
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ppa_pkg::TDATA_W-1:0]   s_tdata,   // [33:0] page_addr_in
	input  logic [ppa_pkg::S_TUSER_W-1:0] s_tuser,   // [1:0] operation, [4:2] cpu_id
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ppa_pkg::TDATA_W-1:0]   m_tdata,   // [33:0] page_addr_out
	output logic [ppa_pkg::M_TUSER_W-1:0] m_tuser,   // [1:0] status
	input  logic                          cfg_we,
	input  logic [ppa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ppa_pkg::ADDR_W-1:0]    cfg_wdata
);
	import ppa_pkg::*;

	localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int PG_W       = $clog2(MAX_PAGES);
	localparam int PB_SH      = $clog2(PAGE_BYTES);
	localparam int WW         = ADDR_W + 2;
	localparam int IDXW       = WW - PB_SH;
	// span = total / NUM_CPUS as floor(total * RCP_M / 2^RCP_SH), exact for
	// a 34-bit total and up to 16 CPUs
	localparam int RC_W       = 13;
	localparam int RCP_SH     = ADDR_W + 4;
	localparam int RCP_W      = 3 * RC_W;
	localparam int PR_W       = ADDR_W + RCP_W;
	localparam int PP_W       = ADDR_W + RC_W;

	localparam logic [WW-1:0]        PAGE_W     = WW'(PAGE_BYTES);
	localparam logic [WW-1:0]        PAGE_MASK  = WW'(PAGE_BYTES - 1);
	localparam logic [WW-1:0]        ORIGIN_RST = (WW'(HEAP_BASE_RST) + PAGE_MASK) & ~PAGE_MASK;
	localparam logic [CPU_W-1:0]     LAST_CPU   = CPU_W'(NUM_CPUS - 1);
	localparam logic [IDXW-1:0]      IDX_LIMIT  = IDXW'(MAX_PAGES);
	localparam logic [LINK_W-1:0]    LINK_LIMIT = LINK_W'(MAX_PAGES);
	localparam logic [RCP_W-1:0]     RCP_M      =
		RCP_W'(((64'd1 << RCP_SH) + 64'(NUM_CPUS) - 64'd1) / 64'(NUM_CPUS));
	localparam logic [1:0]           DIV_FIRST  = 2'd2;

	typedef enum logic [3:0] {
		IDLE, I_CHK, I_DIV, I_SPAN, I_SPAN2, I_PAGE, I_NEXT,
		A_SCAN, A_POP, F_CHK, F_PUSH, NOP, RESP
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0] base_q, limit_q;
	logic [WW-1:0]     origin_q;
	logic [LINK_W-1:0] head_q [NUM_CPUS];
	logic [CPU_W-1:0]  c_q, tries_q;
	logic [ADDR_W-1:0] addr_q;

	logic [ADDR_W-1:0] total_q;
	logic              tneg_q;
	logic [1:0]        div_cnt_q;
	logic [PR_W-1:0]   span_acc_q;
	logic [WW-1:0]     start_q, stop_q, p_q, pend_q;
	logic [IDXW-1:0]   idx_q;
	logic [LINK_W-1:0] prev_q;
	logic [1:0]        ist_q;
	logic              ok_q;

	logic              out_valid_q;
	logic [ADDR_W-1:0] out_page_q, res_page_q;
	logic [1:0]        out_st_q, res_st_q;

	// combinational
	logic [4:0]        cpu_v;
	logic [CPU_W-1:0]  cpu_sel;
	logic [ADDR_W:0]   tot;
	logic [LINK_W-1:0] head_rd;
	logic              head_hit;
	logic              page_fits;
	logic              idx_in_store;
	logic              out_free;
	logic [RC_W-1:0]   rcp_dig;
	logic [PP_W-1:0]   rcp_pp;
	logic [ADDR_W-1:0] span_w;
	logic [WW-1:0]     alloc_addr;
	logic              fin;
	logic [ADDR_W-1:0] fin_page;
	logic [1:0]        fin_st;

	logic              link_we, link_re;
	logic [PG_W-1:0]   link_waddr, link_raddr;
	logic [LINK_W-1:0] link_wdata, link_rdata;

	ppa_link_ram #(
		.DEPTH(MAX_PAGES),
		.AW   (PG_W)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.re   (link_re),
		.raddr(link_raddr),
		.rdata(link_rdata)
	);

	// cpu_id modulo NUM_CPUS by repeated subtraction on a 3-bit value
	always_comb begin
		cpu_v = 5'(s_tuser[4:2]);
		for (int k = 0; k < 8; k++) begin
			if (cpu_v >= 5'(NUM_CPUS)) begin
				cpu_v = cpu_v - 5'(NUM_CPUS);
			end
		end
		cpu_sel = CPU_W'(cpu_v);
	end

	// one 13-bit digit of the reciprocal per cycle, high digit first
	always_comb begin
		case (div_cnt_q)
			2'd2: begin
				rcp_dig = RCP_M[3*RC_W-1:2*RC_W];
			end
			2'd1: begin
				rcp_dig = RCP_M[2*RC_W-1:RC_W];
			end
			default: begin
				rcp_dig = RCP_M[RC_W-1:0];
			end
		endcase
		rcp_pp = PP_W'(total_q) * PP_W'(rcp_dig);
	end

	assign tot          = {1'b0, limit_q} - {1'b0, base_q};
	assign span_w       = span_acc_q[RCP_SH +: ADDR_W];
	assign head_rd      = head_q[c_q];
	assign head_hit     = (head_rd != EMPTY_LINK) && (head_rd < LINK_LIMIT);
	assign page_fits    = (pend_q <= stop_q);
	assign idx_in_store = (idx_q < IDX_LIMIT);
	assign out_free     = !out_valid_q || m_tready;
	assign alloc_addr   = origin_q + (WW'(idx_q) << PB_SH);

	// end of an item and its result
	always_comb begin
		fin      = 1'b0;
		fin_page = '0;
		fin_st   = ST_OK;
		case (state_q)
			I_CHK: begin
				fin = tneg_q || (total_q == '0);
			end
			I_NEXT: begin
				if (c_q == LAST_CPU) begin
					fin    = 1'b1;
					fin_st = ist_q;
				end
			end
			A_SCAN: begin
				if (!head_hit && tries_q == LAST_CPU) begin
					fin    = 1'b1;
					fin_st = ST_OOM;
				end
			end
			A_POP: begin
				fin      = 1'b1;
				fin_page = alloc_addr[ADDR_W-1:0];
			end
			F_PUSH: begin
				fin    = 1'b1;
				fin_st = (ok_q && idx_in_store) ? ST_OK : ST_BAD;
			end
			NOP: begin
				fin = 1'b1;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_comb begin
		link_we    = 1'b0;
		link_waddr = idx_q[PG_W-1:0];
		link_wdata = prev_q;
		if (state_q == I_PAGE && page_fits && idx_in_store) begin
			link_we = 1'b1;
		end
		if (state_q == F_PUSH && ok_q && idx_in_store) begin
			link_we    = 1'b1;
			link_wdata = head_rd;
		end
	end

	assign link_re    = (state_q == A_SCAN) && head_hit;
	assign link_raddr = head_rd[PG_W-1:0];

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(TDATA_W - ADDR_W)'(0), out_page_q};
	assign m_tuser  = out_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			base_q      <= HEAP_BASE_RST;
			limit_q     <= HEAP_LIMIT_RST;
			origin_q    <= ORIGIN_RST;
			out_valid_q <= 1'b0;
			c_q         <= '0;
			tries_q     <= '0;
			for (int i = 0; i < NUM_CPUS; i++) begin
				head_q[i] <= EMPTY_LINK;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_HEAP_BASE: begin
						base_q   <= cfg_wdata;
						origin_q <= (WW'(cfg_wdata) + PAGE_MASK) & ~PAGE_MASK;
					end
					CFG_HEAP_LIMIT: begin
						limit_q <= cfg_wdata;
					end
					default: begin
					end
				endcase
			end

			if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						c_q     <= cpu_sel;
						tries_q <= '0;
						addr_q  <= s_tdata[ADDR_W-1:0];
						case (s_tuser[1:0])
							OP_INIT: begin
								for (int i = 0; i < NUM_CPUS; i++) begin
									head_q[i] <= EMPTY_LINK;
								end
								c_q        <= '0;
								total_q    <= tot[ADDR_W-1:0];
								tneg_q     <= tot[ADDR_W];
								start_q    <= WW'(base_q);
								ist_q      <= ST_OK;
								span_acc_q <= '0;
								div_cnt_q  <= DIV_FIRST;
								state_q    <= I_CHK;
							end
							OP_ALLOC: state_q <= A_SCAN;
							OP_FREE:  state_q <= F_CHK;
							default:  state_q <= NOP;
						endcase
					end
				end
				I_CHK: begin
					state_q <= I_DIV;
				end
				I_DIV: begin
					span_acc_q <= (span_acc_q << RC_W) + PR_W'(rcp_pp);
					div_cnt_q  <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= I_SPAN;
					end
				end
				I_SPAN: begin
					stop_q  <= start_q + WW'(span_w);
					p_q     <= (start_q + PAGE_MASK) & ~PAGE_MASK;
					state_q <= I_SPAN2;
				end
				I_SPAN2: begin
					idx_q   <= IDXW'((p_q - origin_q) >> PB_SH);
					pend_q  <= p_q + PAGE_W;
					prev_q  <= EMPTY_LINK;
					state_q <= I_PAGE;
				end
				I_PAGE: begin
					if (page_fits && idx_in_store) begin
						prev_q <= LINK_W'(idx_q);
						idx_q  <= idx_q + 1'b1;
						pend_q <= pend_q + PAGE_W;
					end else begin
						if (page_fits) begin
							ist_q <= ST_BAD;
						end
						state_q <= I_NEXT;
					end
				end
				I_NEXT: begin
					head_q[c_q] <= prev_q;
					start_q     <= stop_q;
					c_q         <= c_q + 1'b1;
					state_q     <= I_SPAN;
				end
				A_SCAN: begin
					if (head_hit) begin
						idx_q   <= IDXW'(head_rd);
						state_q <= A_POP;
					end else begin
						c_q     <= (c_q == LAST_CPU) ? '0 : c_q + 1'b1;
						tries_q <= tries_q + 1'b1;
					end
				end
				A_POP: begin
					head_q[c_q] <= link_rdata;
				end
				F_CHK: begin
					ok_q <= (addr_q[PB_SH-1:0] == '0) && (addr_q >= base_q) &&
						(addr_q < limit_q);
					idx_q   <= IDXW'(({2'b00, addr_q} - origin_q) >> PB_SH);
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (ok_q && idx_in_store) begin
						head_q[c_q] <= LINK_W'(idx_q);
					end
				end
				RESP: begin
					if (out_free) begin
						out_page_q  <= res_page_q;
						out_st_q    <= res_st_q;
						out_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase

			if (fin) begin
				if (out_free) begin
					out_page_q  <= fin_page;
					out_st_q    <= fin_st;
					out_valid_q <= 1'b1;
					state_q     <= IDLE;
				end else begin
					res_page_q <= fin_page;
					res_st_q   <= fin_st;
					state_q    <= RESP;
				end
			end
		end
	end

	// only a valid list entry is ever popped
	a_pop_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == A_POP |-> idx_q < IDX_LIMIT)
		else $error("pop of a page index beyond the link store");

	a_link_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		link_we |-> {1'b0, link_waddr} < (PG_W + 1)'(MAX_PAGES))
		else $error("link write beyond the store");

	// one word in flight
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("word accepted while busy");

	a_resp_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == RESP |-> out_valid_q)
		else $error("result parked while output register empty");

	a_addr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[ADDR_W-1:0] != '0) |-> m_tuser == ST_OK)
		else $error("page address returned with failing status");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - per-CPU page allocator
// Sends init, alloc, free and unused-opcode words under several heap settings
// and checks every returned page/status word against a free-list model kept
// in step with the block. Both sides idle at random in two of three stages.
// ----------------------------------------------------------------------------
module testbench;
	import ppa_pkg::*;

	localparam int NCPU = 8;
	localparam int NPAGES = 32768;
	localparam int PG = 4096;
	localparam longint unsigned ADDR_MASK = 64'h3_FFFF_FFFF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum logic {JOB_WORD, JOB_CFG} job_kind_e;

	// a stream word, or a register write (addr then holds the write data)
	typedef struct {
		job_kind_e            kind;
		logic [1:0]           op;
		logic [2:0]           cpu;
		logic [ADDR_W-1:0]    addr;
		logic [CFG_IDX_W-1:0] reg_idx;
	} job_t;

	typedef struct {
		logic [1:0]        op;
		logic [ADDR_W-1:0] page;
		logic [1:0]        status;
	} grant_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_wdata = '0;

	job_t   job_q[$];
	grant_t grant_q[$];

	// allocator state as the block should hold it
	logic [LINK_W-1:0] link_ram [NPAGES];
	logic [LINK_W-1:0] heads [NCPU];
	longint unsigned   base_r, limit_r;

	// heap bounds as the stimulus writer last set them
	longint unsigned fill_base, fill_limit;

	int total_words = 0;
	int n_issued = 0;
	int n_checked = 0;
	int errors = 0;
	int cycles = 0;
	int n_init = 0, n_alloc = 0, n_steal = 0, n_oom = 0;
	int n_free = 0, n_bad_free = 0, n_cfg = 0;

	percpu_page_allocator #(
		.NUM_CPUS(NCPU),
		.MAX_PAGES(NPAGES),
		.PAGE_BYTES(PG)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic longint unsigned page_ceil(input longint unsigned a);
		return ((a + PG - 1) / PG) * PG;
	endfunction

	function automatic longint unsigned rand_addr();
		return {30'd0, 2'($urandom_range(0, 3)), $urandom()};
	endfunction

	task automatic queue_word(input logic [1:0] op, input int cpu, input longint unsigned addr);
		job_t j;
		j.kind = JOB_WORD;
		j.op = op;
		j.cpu = cpu[2:0];
		j.addr = addr[ADDR_W-1:0];
		j.reg_idx = '0;
		job_q.push_back(j);
		total_words++;
	endtask

	task automatic queue_cfg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
		job_t j;
		j.kind = JOB_CFG;
		j.op = OP_INIT;
		j.cpu = '0;
		j.addr = val[ADDR_W-1:0];
		j.reg_idx = idx;
		job_q.push_back(j);
		if (idx == CFG_HEAP_BASE) begin
			fill_base = val & ADDR_MASK;
		end else begin
			fill_limit = val & ADDR_MASK;
		end
	endtask

	// one accepted word: update the lists and queue the word the block owes
	task automatic page_alloc_step(input logic [1:0] op, input logic [2:0] cpu_in,
			input logic [ADDR_W-1:0] addr_in);
		grant_t g;
		longint unsigned origin, span, start, stop, p, idx, addr;
		logic [LINK_W-1:0] hd;
		int c, k;
		bit stopped;
		g.op = op;
		g.page = '0;
		g.status = ST_OK;
		origin = page_ceil(base_r);
		addr = addr_in;
		c = cpu_in % NCPU;
		case (op)
			OP_INIT: begin
				n_init++;
				for (k = 0; k < NCPU; k++) heads[k] = EMPTY_LINK;
				if (limit_r > base_r) begin
					span = (limit_r - base_r) / NCPU;
					start = base_r;
					for (k = 0; k < NCPU; k++) begin
						stop = start + span;
						p = page_ceil(start);
						stopped = 1'b0;
						while (!stopped && p + PG <= stop) begin
							idx = (p - origin) / PG;
							if (idx >= NPAGES) begin
								// page past the link store: rest of this span dropped
								g.status = ST_BAD;
								stopped = 1'b1;
							end else begin
								link_ram[idx] = heads[k];
								heads[k] = idx[LINK_W-1:0];
								p += PG;
							end
						end
						start = stop;
					end
				end
			end
			OP_ALLOC: begin
				n_alloc++;
				idx = EMPTY_LINK;
				// own list first, then steal from cpu+1, cpu+2, ... wrapping
				for (k = 0; k < NCPU && idx == EMPTY_LINK; k++) begin
					hd = heads[(c + k) % NCPU];
					if (hd != EMPTY_LINK && hd < NPAGES) begin
						heads[(c + k) % NCPU] = link_ram[hd];
						idx = hd;
						if (k != 0) n_steal++;
					end
				end
				if (idx == EMPTY_LINK) begin
					g.status = ST_OOM;
					n_oom++;
				end else begin
					p = (origin + idx * PG) & ADDR_MASK;
					g.page = p[ADDR_W-1:0];
				end
			end
			OP_FREE: begin
				n_free++;
				if (addr % PG != 0 || addr < base_r || addr >= limit_r) begin
					g.status = ST_BAD;
				end else begin
					idx = (addr - origin) / PG;
					if (idx >= NPAGES) begin
						g.status = ST_BAD;
					end else begin
						link_ram[idx] = heads[c];
						heads[c] = idx[LINK_W-1:0];
					end
				end
				if (g.status == ST_BAD) n_bad_free++;
			end
			default: ;
		endcase
		grant_q.push_back(g);
	endtask

	initial begin : stimulus
		longint unsigned b, sz, origin, npages;
		int ph, n, r, k;
		base_r = HEAP_BASE_RST;
		limit_r = HEAP_LIMIT_RST;
		fill_base = HEAP_BASE_RST;
		fill_limit = HEAP_LIMIT_RST;
		for (k = 0; k < NCPU; k++) heads[k] = EMPTY_LINK;

		// reset bounds; lists start empty
		queue_word(OP_ALLOC, 0, rand_addr());
		queue_word(OP_FREE, 1, HEAP_BASE_RST + 1);
		queue_word(OP_UNUSED, 7, ADDR_MASK);
		queue_word(OP_INIT, 5, rand_addr());
		queue_word(OP_ALLOC, 0, 0);
		queue_word(OP_ALLOC, 7, ADDR_MASK);
		queue_word(OP_FREE, 3, HEAP_LIMIT_RST - PG);
		queue_word(OP_FREE, 3, HEAP_LIMIT_RST);
		queue_word(OP_FREE, 4, HEAP_BASE_RST - PG);
		queue_word(OP_ALLOC, 3, 0);

		// widest heap: only cpu 0 gets pages, the rest lie past the link store
		queue_cfg(CFG_HEAP_BASE, 0);
		queue_cfg(CFG_HEAP_LIMIT, ADDR_MASK);
		queue_word(OP_INIT, 0, 0);
		queue_word(OP_ALLOC, 1, 0);
		queue_word(OP_FREE, 2, longint'(NPAGES) * PG);
		queue_word(OP_FREE, 5, 0);
		queue_word(OP_FREE, 6, ADDR_MASK - (PG - 1));

		// limit below base
		queue_cfg(CFG_HEAP_BASE, ADDR_MASK);
		queue_cfg(CFG_HEAP_LIMIT, 0);
		queue_word(OP_INIT, 2, 0);
		queue_word(OP_ALLOC, 4, 0);

		// spans too short after rounding: a single page, on cpu 0
		queue_cfg(CFG_HEAP_BASE, 64'h1000);
		queue_cfg(CFG_HEAP_LIMIT, 64'h1000 + 8 * PG + 100);
		queue_word(OP_INIT, 0, 0);
		queue_word(OP_ALLOC, 0, 0);
		queue_word(OP_ALLOC, 0, 0);
		queue_word(OP_FREE, 6, 64'h1000);
		queue_word(OP_FREE, 6, 64'h1000);
		queue_word(OP_ALLOC, 2, 0);
		queue_word(OP_ALLOC, 2, 0);
		// moved base without re-init: old indices map onto the new origin
		queue_cfg(CFG_HEAP_BASE, 64'h3000);
		queue_word(OP_ALLOC, 6, 0);

		for (ph = 0; ph < 7; ph++) begin
			b = rand_addr();
			if (ph % 2 == 0) b = b - b % PG;
			if (b > ADDR_MASK - 64'h80000) b -= 64'h80000;
			sz = longint'($urandom_range(0, 64)) * PG + $urandom_range(0, PG - 1);
			queue_cfg(CFG_HEAP_BASE, b);
			queue_cfg(CFG_HEAP_LIMIT, (ph == 2) ? b : b + sz);
			origin = page_ceil(fill_base);
			npages = (fill_limit > origin) ? (fill_limit - origin) / PG : 0;
			if ($urandom_range(0, 4) != 0) begin
				queue_word(OP_INIT, $urandom_range(0, NCPU - 1), rand_addr());
			end
			for (n = 0; n < 100; n++) begin
				r = $urandom_range(0, 99);
				if (r < 45 || r >= 97) begin
					queue_word(OP_ALLOC, $urandom_range(0, NCPU - 1), rand_addr());
				end else if (r < 80) begin
					// page-aligned, mostly inside the heap, now and then just past it
					queue_word(OP_FREE, $urandom_range(0, NCPU - 1),
						origin + longint'($urandom_range(0, npages + 1)) * PG);
				end else if (r < 84) begin
					queue_word(OP_FREE, $urandom_range(0, NCPU - 1), rand_addr());
				end else if (r < 88) begin
					queue_word(OP_FREE, $urandom_range(0, NCPU - 1),
						origin + longint'($urandom_range(0, npages)) * PG
						+ $urandom_range(1, PG - 1));
				end else if (r < 94) begin
					queue_word(OP_INIT, $urandom_range(0, NCPU - 1), rand_addr());
				end else begin
					queue_word(OP_UNUSED, $urandom_range(0, NCPU - 1), rand_addr());
				end
			end
		end
	end

	// driver: words and register writes in queue order; writes only when idle
	always @(posedge clk or negedge arst_n) begin : driver
		job_t j;
		logic nv, we;
		int idle_pct;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			cfg_we <= 1'b0;
			cfg_index <= '0;
			cfg_wdata <= '0;
			n_issued <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				page_alloc_step(s_tuser[1:0], s_tuser[4:2], s_tdata[ADDR_W-1:0]);
				n_issued <= n_issued + 1;
			end
			idle_pct = (n_issued * 3 < total_words) ? 19 :
				(n_issued * 3 < total_words * 2) ? 57 : 0;
			nv = s_tvalid && !s_tready;
			we = 1'b0;
			if (!nv && job_q.size() != 0) begin
				j = job_q[0];
				if (j.kind == JOB_CFG) begin
					if (!s_tvalid && n_issued == n_checked) begin
						we = 1'b1;
						cfg_index <= j.reg_idx;
						cfg_wdata <= j.addr;
						if (j.reg_idx == CFG_HEAP_BASE) begin
							base_r = j.addr;
						end else begin
							limit_r = j.addr;
						end
						n_cfg++;
						void'(job_q.pop_front());
					end
				end else if ($urandom_range(0, 99) >= idle_pct) begin
					nv = 1'b1;
					s_tuser <= {j.cpu, j.op};
					s_tdata <= {{(TDATA_W - ADDR_W){1'b0}}, j.addr};
					void'(job_q.pop_front());
				end
			end
			s_tvalid <= nv;
			cfg_we <= we;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		grant_t g;
		int stall_pct;
		if (!arst_n) begin
			m_tready <= 1'b0;
			n_checked <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_checked <= n_checked + 1;
				if (grant_q.size() == 0) begin
					errors++;
					$display("%0t ns: word with nothing pending: page %h status %0d",
						$time, m_tdata[ADDR_W-1:0], m_tuser);
				end else begin
					g = grant_q.pop_front();
					if (m_tdata[ADDR_W-1:0] !== g.page) begin
						errors++;
						$display("%0t ns: page mismatch (op %0d): expected %h, got %h",
							$time, g.op, g.page, m_tdata[ADDR_W-1:0]);
					end
					if (m_tuser[1:0] !== g.status) begin
						errors++;
						$display("%0t ns: status mismatch (op %0d): expected %0d, got %0d",
							$time, g.op, g.status, m_tuser[1:0]);
					end
				end
			end
			stall_pct = (n_checked * 3 < total_words) ? 57 :
				(n_checked * 3 < total_words * 2) ? 19 : 0;
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d words returned",
				cycles, n_checked, total_words);
			$display("testbench failed");
			$finish;
		end
	end

	initial begin : finish_run
		wait (arst_n === 1'b1);
		do @(negedge clk);
		while (job_q.size() != 0 || s_tvalid || n_issued != n_checked);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (grant_q.size() != 0) begin
			errors++;
			$display("%0t ns: %0d words never returned", $time, grant_q.size());
		end
		$display("%0d words: %0d init, %0d alloc (%0d stolen, %0d out of memory),",
			total_words, n_init, n_alloc, n_steal, n_oom);
		$display("%0d free (%0d rejected), %0d register writes, %0d errors",
			n_free, n_bad_free, n_cfg, errors);
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

// ===== percpu_page_allocator.f =====
src/ppa_pkg.sv
src/ppa_link_ram.sv
src/percpu_page_allocator.sv
tb/testbench.sv
